/* design/itp_pkg.sv */
// Shared types, constants and character helpers for the infix to prefix converter.
// No dependencies; itp_core and the top level refer to it by scoped names.

package itp_pkg;

	// Expression capacity and derived widths
	localparam int MAX_LEN = 64;
	localparam int AW      = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);

	// Character codes
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DIG_LO = 8'h30;
	localparam logic [7:0] CH_DIG_HI = 8'h39;
	localparam logic [7:0] CH_UC_LO  = 8'h41;
	localparam logic [7:0] CH_UC_HI  = 8'h5A;
	localparam logic [7:0] CH_LC_LO  = 8'h61;
	localparam logic [7:0] CH_LC_HI  = 8'h7A;

	// Converter sequencer states
	typedef enum logic [3:0] {
		S_LOAD,
		S_SCAN,
		S_CLASS,
		S_CLOSE,
		S_OPER,
		S_TOPWAIT,
		S_DRAIN,
		S_OUT_RD,
		S_OUT
	} state_t;

	// One prefix character on its way to the output register
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       ovf;
	} res_t;

	// Operator precedence; unknown symbols rank lowest
	function automatic logic signed [2:0] prec(input logic [7:0] c);
		logic signed [2:0] p;
		unique case (c)
			CH_HASH:            p = 3'sd0;
			CH_PLUS, CH_MINUS:  p = 3'sd1;
			CH_STAR, CH_SLASH:  p = 3'sd2;
			CH_CARET:           p = 3'sd3;
			default:            p = -3'sd1;
		endcase
		return p;
	endfunction

	// Letters and digits only
	function automatic logic is_operand(input logic [7:0] c);
		return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
		       (c >= CH_UC_LO && c <= CH_UC_HI) ||
		       (c >= CH_LC_LO && c <= CH_LC_HI);
	endfunction

	// Swap brackets for the reversed scan
	function automatic logic [7:0] swap_paren(input logic [7:0] c);
		logic [7:0] r;
		if (c == CH_LPAREN) begin
			r = CH_RPAREN;
		end else if (c == CH_RPAREN) begin
			r = CH_LPAREN;
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

/* design/itp_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.

module itp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

/* design/itp_core.sv */
// Conversion sequencer: input buffer RAM, shared stack/output RAM and the control FSM.
// Depends on itp_pkg and itp_ram.

module itp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_char,
	input  logic          in_last,
	output logic          res_valid,
	input  logic          res_ready,
	output itp_pkg::res_t res
);

	localparam int AW    = itp_pkg::AW;
	localparam int CNT_W = itp_pkg::CNT_W;

	itp_pkg::state_t st_q, st_d, ret_q, ret_d;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] sp_q, sp_d;
	logic [CNT_W-1:0] oc_q, oc_d;
	logic             ovf_q, ovf_d;
	logic [7:0]       top_q, top_d;
	logic [7:0]       cur_q, cur_d;

	// RAM ports
	logic          in_we, in_re;
	logic [AW-1:0] in_waddr, in_raddr;
	logic [7:0]    in_rdata;
	logic          ws_we, ws_re;
	logic [AW:0]   ws_waddr, ws_raddr;
	logic [7:0]    ws_wdata, ws_rdata;

	logic             do_pop, pop_emit, stored;
	logic [7:0]       rd_ch;
	logic [CNT_W-1:0] sp_m1, sp_m2, oc_m1, idx_m1;

	// Input characters in arrival order
	itp_ram #(.DEPTH(itp_pkg::MAX_LEN), .WIDTH(8)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (in_char),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	// Lower half holds the operator stack, upper half the prefix string in build order
	itp_ram #(.DEPTH(2 * itp_pkg::MAX_LEN), .WIDTH(8)) u_ws_ram (
		.clk   (clk),
		.we    (ws_we),
		.waddr (ws_waddr),
		.wdata (ws_wdata),
		.re    (ws_re),
		.raddr (ws_raddr),
		.rdata (ws_rdata)
	);

	assign rd_ch  = itp_pkg::swap_paren(in_rdata);
	assign stored = (cnt_q < CNT_W'(itp_pkg::MAX_LEN));
	assign sp_m1  = sp_q - CNT_W'(1);
	assign sp_m2  = sp_q - CNT_W'(2);
	assign oc_m1  = oc_q - CNT_W'(1);
	assign idx_m1 = idx_q - CNT_W'(1);

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= itp_pkg::S_LOAD;
			ret_q <= itp_pkg::S_SCAN;
			cnt_q <= '0;
			idx_q <= '0;
			sp_q  <= '0;
			oc_q  <= '0;
			ovf_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			ret_q <= ret_d;
			cnt_q <= cnt_d;
			idx_q <= idx_d;
			sp_q  <= sp_d;
			oc_q  <= oc_d;
			ovf_q <= ovf_d;
		end
	end

	// Cached stack top and the symbol under evaluation
	always_ff @(posedge clk) begin
		top_q <= top_d;
		cur_q <= cur_d;
	end

	// Next state, RAM accesses and handshakes
	always_comb begin
		st_d      = st_q;
		ret_d     = ret_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		sp_d      = sp_q;
		oc_d      = oc_q;
		ovf_d     = ovf_q;
		top_d     = top_q;
		cur_d     = cur_q;
		in_ready  = 1'b0;
		in_we     = 1'b0;
		in_waddr  = cnt_q[AW-1:0];
		in_re     = 1'b0;
		in_raddr  = idx_m1[AW-1:0];
		ws_we     = 1'b0;
		ws_waddr  = {1'b0, sp_q[AW-1:0]};
		ws_wdata  = cur_q;
		ws_re     = 1'b0;
		ws_raddr  = {1'b1, oc_m1[AW-1:0]};
		res_valid = 1'b0;
		res.ch    = ws_rdata;
		res.last  = (oc_q == '0);
		res.ovf   = ovf_q;
		do_pop    = 1'b0;
		pop_emit  = 1'b0;

		unique case (st_q)
			itp_pkg::S_LOAD: begin
				// store the character or flag it as dropped
				in_ready = 1'b1;
				if (in_valid) begin
					if (stored) begin
						in_we = 1'b1;
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (in_last) begin
						idx_d = stored ? cnt_q + CNT_W'(1) : cnt_q;
						sp_d  = '0;
						oc_d  = '0;
						st_d  = itp_pkg::S_SCAN;
					end
				end
			end
			itp_pkg::S_SCAN: begin
				// fetch the next character from the end backward
				if (idx_q == '0) begin
					st_d = itp_pkg::S_DRAIN;
				end else begin
					in_re = 1'b1;
					idx_d = idx_m1;
					st_d  = itp_pkg::S_CLASS;
				end
			end
			itp_pkg::S_CLASS: begin
				cur_d = rd_ch;
				if (itp_pkg::is_operand(rd_ch)) begin
					if (oc_q < CNT_W'(itp_pkg::MAX_LEN)) begin
						ws_we    = 1'b1;
						ws_waddr = {1'b1, oc_q[AW-1:0]};
						ws_wdata = rd_ch;
						oc_d     = oc_q + CNT_W'(1);
					end
					st_d = itp_pkg::S_SCAN;
				end else if (rd_ch == itp_pkg::CH_LPAREN) begin
					if (sp_q < CNT_W'(itp_pkg::MAX_LEN)) begin
						ws_we    = 1'b1;
						ws_wdata = rd_ch;
						top_d    = rd_ch;
						sp_d     = sp_q + CNT_W'(1);
					end
					st_d = itp_pkg::S_SCAN;
				end else if (rd_ch == itp_pkg::CH_RPAREN) begin
					st_d = itp_pkg::S_CLOSE;
				end else begin
					st_d = itp_pkg::S_OPER;
				end
			end
			itp_pkg::S_CLOSE: begin
				// pop down to the matching bracket, then drop it
				if (sp_q != '0 && top_q != itp_pkg::CH_LPAREN) begin
					do_pop   = 1'b1;
					pop_emit = 1'b1;
					ret_d    = itp_pkg::S_CLOSE;
				end else if (sp_q != '0) begin
					do_pop = 1'b1;
					ret_d  = itp_pkg::S_SCAN;
				end else begin
					st_d = itp_pkg::S_SCAN;
				end
			end
			itp_pkg::S_OPER: begin
				// pop higher precedence, then push
				if (sp_q != '0 && (itp_pkg::prec(cur_q) < itp_pkg::prec(top_q))) begin
					do_pop   = 1'b1;
					pop_emit = 1'b1;
					ret_d    = itp_pkg::S_OPER;
				end else begin
					if (sp_q < CNT_W'(itp_pkg::MAX_LEN)) begin
						ws_we = 1'b1;
						top_d = cur_q;
						sp_d  = sp_q + CNT_W'(1);
					end
					st_d = itp_pkg::S_SCAN;
				end
			end
			itp_pkg::S_TOPWAIT: begin
				// refill the cached top from the stack read
				top_d = ws_rdata;
				st_d  = ret_q;
			end
			itp_pkg::S_DRAIN: begin
				if (sp_q != '0) begin
					do_pop   = 1'b1;
					pop_emit = (top_q != itp_pkg::CH_LPAREN) && (top_q != itp_pkg::CH_RPAREN);
					ret_d    = itp_pkg::S_DRAIN;
				end else if (oc_q != '0) begin
					st_d = itp_pkg::S_OUT_RD;
				end else begin
					cnt_d = '0;
					ovf_d = 1'b0;
					st_d  = itp_pkg::S_LOAD;
				end
			end
			itp_pkg::S_OUT_RD: begin
				// read the last built character first
				ws_re = 1'b1;
				oc_d  = oc_m1;
				st_d  = itp_pkg::S_OUT;
			end
			itp_pkg::S_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (oc_q == '0) begin
						cnt_d = '0;
						ovf_d = 1'b0;
						st_d  = itp_pkg::S_LOAD;
					end else begin
						ws_re = 1'b1;
						oc_d  = oc_m1;
					end
				end
			end
			default: begin
				st_d = itp_pkg::S_LOAD;
			end
		endcase

		// Pop: emit the cached top, read the entry below it as the new top.
		// Stack and output halves never share an address, so no forwarding is needed.
		if (do_pop) begin
			sp_d     = sp_m1;
			ws_re    = 1'b1;
			ws_raddr = {1'b0, sp_m2[AW-1:0]};
			st_d     = itp_pkg::S_TOPWAIT;
			if (pop_emit && oc_q < CNT_W'(itp_pkg::MAX_LEN)) begin
				ws_we    = 1'b1;
				ws_waddr = {1'b1, oc_q[AW-1:0]};
				ws_wdata = top_q;
				oc_d     = oc_q + CNT_W'(1);
			end
		end
	end

endmodule

/* design/infix_to_prefix_converter.sv */
// Top level of the infix to prefix converter: conversion core plus the output register.
// Depends on itp_pkg and itp_core.

// An expression enters one character per cycle while in_ready is high; the transaction
// with in_last set starts the conversion, and in_ready stays low until the last prefix
// character has left the core. Up to 64 characters are kept, later ones are dropped and
// reported through out_overflow on every result. Conversion runs from a shared
// stack/output RAM with registered reads: each character is fetched and classified, an
// operator or a closing bracket is then compared with the cached stack top, and each
// stack pop refills that top through a stack read. The prefix string then streams out
// at one character per cycle while out_ready does not stall it. An expression whose
// prefix form is empty gives no result.

module infix_to_prefix_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last,
	output logic       out_overflow
);

	itp_pkg::res_t res;
	logic          res_valid, res_ready;
	logic          out_valid_q;
	itp_pkg::res_t out_q;

	itp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_char   (in_char),
		.in_last   (in_last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Take a new result whenever the register is empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload until the next load
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_q.ch;
	assign out_last     = out_q.last;
	assign out_overflow = out_q.ovf;

endmodule

/* design/itp_checker.sv */
// Port-level checks for the infix to prefix converter, bound to the top level.
// Depends only on the top level's ports.

module itp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_char,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last,
	input logic       out_overflow
);

	// Stop taking characters once the closing transaction arrives
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready)
		else $error("input accepted right after final character");

	// No new expression while a result string is still streaming
	a_busy_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last) |-> !in_ready)
		else $error("input ready in the middle of a result string");

	// Overflow mark is the same across one result string
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=> $stable(out_overflow))
		else $error("overflow mark changed within a result string");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
		else $error("stalled output transaction changed");

endmodule

bind infix_to_prefix_converter itp_checker u_itp_checker (.*);

/* verif/infix_to_prefix_converter_tb.sv */
// Self-checking testbench for infix_to_prefix_converter: directed rows, then random expressions.
// Depends on itp_pkg for character codes, capacity and the result record type.

module infix_to_prefix_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Receiver stall patterns
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_SLOW} rx_mode_t;

	// One directed row: pad copies of "a+" go in front of expr; '@' in expr stands for NUL
	typedef struct {
		string expr;
		int    pad;
		bit    typed;
		string want;
	} row_t;

	localparam logic [7:0] NUL_MARK = "@";
	localparam int SETTLE_CYCLES = 400;
	localparam int RANDOM_ITEMS  = 14;

	row_t rows[$] = '{
		'{"A",             0,  1'b1, "A"},
		'{"A+B",           0,  1'b1, "+AB"},
		'{"+",             0,  1'b1, "+"},
		'{"(",             0,  1'b1, ""},
		'{"()",            0,  1'b1, ""},
		'{")",             0,  1'b1, ""},
		'{"A*B+C",         0,  1'b0, ""},
		'{"A-B/C^D",       0,  1'b0, ""},
		'{"A^B^C",         0,  1'b0, ""},
		'{"A-B-C",         0,  1'b0, ""},
		'{"(A+B)*(C-D)",   0,  1'b0, ""},
		'{"a*(b+c)^d-e/f", 0,  1'b0, ""},
		'{"A)+B",          0,  1'b0, ""},
		'{"((A+B",         0,  1'b0, ""},
		'{"A#B*C",         0,  1'b0, ""},
		'{"A B?C",         0,  1'b0, ""},
		'{"@A\377",        0,  1'b0, ""},
		'{"09AZaz",        0,  1'b0, ""},
		'{"/:[`{~",        0,  1'b0, ""},
		'{"bc",            31, 1'b0, ""},
		'{"z",             32, 1'b0, ""}
	};

	string alnum_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
	string oper_set  = "+-*/^#+-*/";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_char = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       out_last;
	logic       out_overflow;

	// Sideband that travels with each input transaction
	logic typed_sb = 1'b0;
	int   row_sb = 0;

	logic [7:0]    chars_held[$];
	logic          dropped_seen = 1'b0;
	itp_pkg::res_t prefix_q[$];
	int            errors = 0;
	int            burst_left = 0;
	int            rx_cycle = 0;
	rx_mode_t      rx_mode = RX_OPEN;

	infix_to_prefix_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.out_last    (out_last),
		.out_overflow(out_overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int rank_of(input logic [7:0] c);
		case (c)
			itp_pkg::CH_HASH:                    return 0;
			itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return 1;
			itp_pkg::CH_STAR, itp_pkg::CH_SLASH: return 2;
			itp_pkg::CH_CARET:                   return 3;
			default:                             return -1;
		endcase
	endfunction

	function automatic bit is_alnum(input logic [7:0] c);
		return (c >= itp_pkg::CH_DIG_LO && c <= itp_pkg::CH_DIG_HI) ||
		       (c >= itp_pkg::CH_UC_LO && c <= itp_pkg::CH_UC_HI) ||
		       (c >= itp_pkg::CH_LC_LO && c <= itp_pkg::CH_LC_HI);
	endfunction

	// Convert the held expression and queue its prefix characters
	function automatic void build_prefix(input logic [7:0] expr[$], input logic dropped);
		logic [7:0]    ops[$];
		logic [7:0]    built[$];
		logic [7:0]    c;
		itp_pkg::res_t r;
		for (int i = expr.size() - 1; i >= 0; i--) begin
			c = expr[i];
			if (c == itp_pkg::CH_LPAREN) begin
				c = itp_pkg::CH_RPAREN;
			end else if (c == itp_pkg::CH_RPAREN) begin
				c = itp_pkg::CH_LPAREN;
			end
			if (is_alnum(c)) begin
				built.push_back(c);
			end else if (c == itp_pkg::CH_LPAREN) begin
				ops.push_back(c);
			end else if (c == itp_pkg::CH_RPAREN) begin
				while (ops.size() != 0 && ops[$] != itp_pkg::CH_LPAREN)
					built.push_back(ops.pop_back());
				if (ops.size() != 0)
					void'(ops.pop_back());
			end else begin
				while (ops.size() != 0 && rank_of(c) < rank_of(ops[$]))
					built.push_back(ops.pop_back());
				ops.push_back(c);
			end
		end
		// Drain what is left; brackets vanish
		while (ops.size() != 0) begin
			c = ops.pop_back();
			if (c != itp_pkg::CH_LPAREN && c != itp_pkg::CH_RPAREN)
				built.push_back(c);
		end
		for (int k = built.size() - 1; k >= 0; k--) begin
			r.ch   = built[k];
			r.last = (k == 0);
			r.ovf  = dropped;
			prefix_q.push_back(r);
		end
	endfunction

	// Random expression: mostly well formed, some broken, some noise, a few over capacity
	function automatic void make_expr(ref logic [7:0] q[$]);
		int kind;
		int nops;
		int depth;
		int idx;
		kind = $urandom_range(0, 99);
		q.delete();
		if (kind < 5) begin
			nops = $urandom_range(60, 72);
			for (int k = 0; k < nops; k++) begin
				if (k % 2 == 0)
					q.push_back(alnum_set[$urandom_range(0, alnum_set.len() - 1)]);
				else
					q.push_back(oper_set[$urandom_range(0, oper_set.len() - 1)]);
			end
		end else if (kind < 88) begin
			nops = $urandom_range(0, 6);
			depth = 0;
			for (int k = 0; k <= nops; k++) begin
				while (depth < 3 && $urandom_range(0, 3) == 0) begin
					q.push_back(itp_pkg::CH_LPAREN);
					depth++;
				end
				q.push_back(alnum_set[$urandom_range(0, alnum_set.len() - 1)]);
				while (depth > 0 && $urandom_range(0, 2) == 0) begin
					q.push_back(itp_pkg::CH_RPAREN);
					depth--;
				end
				if (k < nops)
					q.push_back(oper_set[$urandom_range(0, oper_set.len() - 1)]);
			end
			while (depth > 0) begin
				q.push_back(itp_pkg::CH_RPAREN);
				depth--;
			end
			// Break some of them
			if (kind >= 75) begin
				idx = $urandom_range(0, q.size() - 1);
				q[idx] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1) == 1)
					q.insert($urandom_range(0, q.size()),
					         ($urandom_range(0, 1) == 1) ? itp_pkg::CH_LPAREN :
					                                       itp_pkg::CH_RPAREN);
			end
		end else begin
			nops = $urandom_range(1, 8);
			for (int k = 0; k < nops; k++)
				q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH %0t ns: %s", $time, what);
	endtask

	task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
	                         input int row);
		in_valid <= 1'b1;
		in_char  <= c;
		in_last  <= fin;
		typed_sb <= typed;
		row_sb   <= row;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Send one expression in bursts with random gaps
	task automatic send_expr(input logic [7:0] q[$], input logic typed, input int row);
		int gap;
		for (int i = 0; i < q.size(); i++) begin
			send_char(q[i], i == q.size() - 1, typed, row);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	// Receiver stall pattern, picked at random from the four modes
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 37 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= (rx_cycle % 4 == 0);
			default:   out_ready <= (rx_cycle % 8 < 5);
		endcase
	end

	// Track input transactions and check output transactions
	always @(posedge clk) begin
		itp_pkg::res_t want;
		string         text;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (chars_held.size() < itp_pkg::MAX_LEN)
					chars_held.push_back(in_char);
				else
					dropped_seen = 1'b1;
				if (in_last) begin
					if (typed_sb) begin
						text = rows[row_sb].want;
						for (int k = 0; k < text.len(); k++) begin
							want.ch   = text[k];
							want.last = (k == text.len() - 1);
							want.ovf  = 1'b0;
							prefix_q.push_back(want);
						end
					end else begin
						build_prefix(chars_held, dropped_seen);
					end
					chars_held.delete();
					dropped_seen = 1'b0;
				end
			end
			if (out_valid && out_ready) begin
				if (prefix_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result char %02h last %b ovf %b",
					                          out_char, out_last, out_overflow));
				end else begin
					want = prefix_q.pop_front();
					if (out_char !== want.ch || out_last !== want.last ||
					    out_overflow !== want.ovf)
						report_mismatch($sformatf(
							"got char %02h last %b ovf %b, want char %02h last %b ovf %b",
							out_char, out_last, out_overflow, want.ch, want.last, want.ovf));
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [7:0] q[$];
		int         items;
		items = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows
		for (int r = 0; r < rows.size(); r++) begin
			q.delete();
			for (int p = 0; p < rows[r].pad; p++) begin
				q.push_back("a");
				q.push_back(itp_pkg::CH_PLUS);
			end
			for (int i = 0; i < rows[r].expr.len(); i++)
				q.push_back((rows[r].expr[i] == NUL_MARK) ? 8'h00 : rows[r].expr[i]);
			send_expr(q, rows[r].typed, r);
		end

		// Random expressions
		while (items < RANDOM_ITEMS) begin
			make_expr(q);
			items += q.size();
			send_expr(q, 1'b0, 0);
		end
		in_valid <= 1'b0;

		// Drain and let the block settle
		while (prefix_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && prefix_q.size() == 0) begin
			$display("infix_to_prefix_converter_tb passed");
		end else begin
			$display("infix_to_prefix_converter_tb failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("infix_to_prefix_converter_tb failed");
		$finish;
	end

endmodule

/* infix_to_prefix_converter.f */
design/itp_pkg.sv
design/itp_ram.sv
design/itp_core.sv
design/infix_to_prefix_converter.sv
design/itp_checker.sv
verif/infix_to_prefix_converter_tb.sv
